[rtl/core/ebrd_pkg.sv]
// Shared types, constants and register codes for the ECG beat rate detector.
package ebrd_pkg;

    localparam int SMOOTH_TAPS_DEF = 10;
    localparam int RATE_TAPS_DEF   = 5;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TENTHS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_HIGH  = 3'd5;

    localparam logic [9:0]  SAMPLE_INIT  = 10'd512;
    localparam logic [9:0]  LEVEL_MAX    = 10'd1023;
    localparam logic [16:0] RATE_NUMER   = 17'd60000;

    typedef struct packed {
        logic [9:0]  raw_sample;
        logic [31:0] time_ms;
    } in_item_t;

    typedef struct packed {
        logic [9:0] smoothed_sample;
        logic [9:0] level_threshold;
        logic       beat_confirmed;
        logic [7:0] instant_rate;
        logic [7:0] average_rate;
    } out_item_t;

    typedef struct packed {
        logic [15:0] min_gap;
        logic [15:0] max_gap;
        logic [15:0] period;
        logic [3:0]  tenths;
        logic [7:0]  rate_low;
        logic [7:0]  rate_high;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture input, write sample window
        logic sum_step;   // accumulate one window tap
        logic thr_step;   // register the smoothed value
        logic beat_step;  // min/max and threshold update
        logic div_start;  // arming and confirmation decision, start rate division
        logic div_step;   // one divider iteration
        logic avg_start;  // add rate to window, start average division
        logic avg_step;   // one average-divider iteration
        logic finish;     // write result register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sum_done;
        logic need_div;
        logic div_done;
        logic need_avg;
        logic avg_done;
    } dp_sts_t;

endpackage

[rtl/core/ebrd_datapath.sv]
// Datapath of the ECG beat rate detector: windows, threshold, dividers.
module ebrd_datapath #(
    parameter int SMOOTH_TAPS = ebrd_pkg::SMOOTH_TAPS_DEF,
    parameter int RATE_TAPS   = ebrd_pkg::RATE_TAPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ebrd_pkg::cfg_t      cfg,
    input  ebrd_pkg::in_item_t  in_item,
    input  ebrd_pkg::dp_cmd_t   cmd,
    output ebrd_pkg::dp_sts_t   sts,
    output ebrd_pkg::out_item_t result
);

    localparam int SP_W   = (SMOOTH_TAPS > 1) ? $clog2(SMOOTH_TAPS) : 1;
    localparam int SC_W   = $clog2(SMOOTH_TAPS + 1);
    localparam int SSUM_W = 10 + SC_W;
    localparam int RP_W   = (RATE_TAPS > 1) ? $clog2(RATE_TAPS) : 1;
    localparam int RC_W   = $clog2(RATE_TAPS + 1);
    localparam int RSUM_W = 8 + RC_W;
    localparam int QD_W   = 17;
    localparam int AQ_W   = RSUM_W;

    // Reciprocal of the tap count, scaled so that the product gives the exact floor.
    localparam int RECIP_K = SSUM_W + $clog2(SMOOTH_TAPS) + 1;
    localparam int RM_W    = RECIP_K + 1;
    localparam int SPROD_W = SSUM_W + RM_W;
    localparam logic [RM_W-1:0] RECIP_M =
        RM_W'(((64'd1 << RECIP_K) + 64'(SMOOTH_TAPS) - 64'd1) / 64'(SMOOTH_TAPS));

    // Sample window held as individual taps, reset to mid-scale.
    logic [9:0]        win_reg [SMOOTH_TAPS];
    logic [SP_W-1:0]   wptr_reg;
    logic [SC_W-1:0]   scnt_reg;
    logic [SSUM_W-1:0] ssum_reg;
    logic [31:0]       now_reg;
    logic [9:0]        f_reg;
    logic [9:0]        prev_reg;
    logic [9:0]        rmax_reg;
    logic [9:0]        rmin_reg;
    logic [9:0]        thr_reg;
    logic [31:0]       lthr_reg;
    logic              track_reg;
    logic [9:0]        peak_reg;
    logic [31:0]       lbeat_reg;
    logic              seen_reg;
    logic [31:0]       gap_reg;
    logic              conf_reg;
    logic [7:0]        inst_reg;
    logic              needdiv_reg;
    logic [7:0]        rwin_reg [RATE_TAPS];
    logic [RP_W-1:0]   rptr_reg;
    logic [RC_W-1:0]   rcnt_reg;
    logic [RSUM_W-1:0] rsum_reg;
    logic [7:0]        cur_reg;
    logic              needavg_reg;
    logic [QD_W-1:0]   dq_reg;
    logic [QD_W-1:0]   drem_reg;
    logic [4:0]        dcnt_reg;
    logic [AQ_W-1:0]   aq_reg;
    logic [RC_W:0]     arem_reg;
    logic [4:0]        acnt_reg;
    ebrd_pkg::out_item_t res_reg;

    // Floor of a value below 16384 divided by ten, by reciprocal multiplication.
    function automatic logic [10:0] div_by_ten(input logic [13:0] x);
        logic [27:0] p;
        p = {14'd0, x} * 28'd6554;
        return p[26:16];
    endfunction

    // Smoothed value: sum times the scaled reciprocal of the tap count.
    logic [SPROD_W-1:0] sprod;
    logic [9:0]         avg_div;
    assign sprod   = SPROD_W'(ssum_reg) * SPROD_W'(RECIP_M);
    assign avg_div = sprod[RECIP_K +: 10];

    // Threshold arithmetic on the freshly smoothed value.
    logic [9:0]  mx, mn, range;
    logic [13:0] prod;
    logic [10:0] tadd;
    logic [10:0] mx9, mn9;
    logic        refresh;
    always_comb
    begin
        mx      = (f_reg > rmax_reg) ? f_reg : rmax_reg;
        mn      = (f_reg < rmin_reg) ? f_reg : rmin_reg;
        range   = mx - mn;
        prod    = range * cfg.tenths;
        tadd    = {1'b0, mn} + div_by_ten(prod);
        mx9     = div_by_ten(14'(mx) * 14'd9 + 14'(f_reg));
        mn9     = div_by_ten(14'(mn) * 14'd9 + 14'(f_reg));
        refresh = (now_reg - lthr_reg) > {16'd0, cfg.period};
    end

    // Beat decision on the updated threshold.
    logic [31:0] gap;
    logic        arm, trk, conf, ndiv;
    logic [9:0]  pk;
    always_comb
    begin
        gap  = now_reg - lbeat_reg;
        arm  = !track_reg && f_reg > thr_reg && prev_reg <= thr_reg
               && gap > {16'd0, cfg.min_gap};
        trk  = track_reg || arm;
        pk   = arm ? f_reg : peak_reg;
        conf = 1'b0;
        ndiv = 1'b0;
        if (trk && !(f_reg > pk) && f_reg < thr_reg)
        begin
            conf = 1'b1;
            ndiv = seen_reg && gap < {16'd0, cfg.max_gap};
        end
    end

    // Restoring-division trial subtractions.
    logic [QD_W:0]   dtrial;
    logic [32:0]     dsub;
    logic [RC_W:0]   atrial;
    always_comb
    begin
        dtrial = {drem_reg, dq_reg[QD_W-1]};
        dsub   = {15'd0, dtrial} - {1'b0, gap_reg};
        atrial = {arem_reg[RC_W-1:0], aq_reg[AQ_W-1]};
    end

    logic          rate_ok;
    logic [RSUM_W-1:0] rsum_new;
    assign rate_ok = dq_reg >= QD_W'(cfg.rate_low) && dq_reg <= QD_W'(cfg.rate_high);
    assign rsum_new = (rcnt_reg < RC_W'(RATE_TAPS))
                      ? rsum_reg + RSUM_W'(dq_reg[7:0])
                      : rsum_reg - RSUM_W'(rwin_reg[rptr_reg]) + RSUM_W'(dq_reg[7:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SMOOTH_TAPS; i++)
                win_reg[i] <= ebrd_pkg::SAMPLE_INIT;
            for (int i = 0; i < RATE_TAPS; i++)
                rwin_reg[i] <= 8'd0;
            wptr_reg    <= '0;
            scnt_reg    <= '0;
            ssum_reg    <= '0;
            now_reg     <= '0;
            f_reg       <= '0;
            prev_reg    <= '0;
            rmax_reg    <= '0;
            rmin_reg    <= ebrd_pkg::LEVEL_MAX;
            thr_reg     <= ebrd_pkg::SAMPLE_INIT;
            lthr_reg    <= '0;
            track_reg   <= 1'b0;
            peak_reg    <= '0;
            lbeat_reg   <= '0;
            seen_reg    <= 1'b0;
            gap_reg     <= '0;
            inst_reg    <= '0;
            rptr_reg    <= '0;
            rcnt_reg    <= '0;
            rsum_reg    <= '0;
            cur_reg     <= '0;
            needdiv_reg <= 1'b0;
            needavg_reg <= 1'b0;
            conf_reg    <= 1'b0;
            dq_reg      <= '0;
            drem_reg    <= '0;
            dcnt_reg    <= '0;
            aq_reg      <= '0;
            arem_reg    <= '0;
            acnt_reg    <= '0;
        end
        else
        begin
            // Capture the transaction and write the new sample into the window.
            if (cmd.load)
            begin
                now_reg           <= in_item.time_ms;
                win_reg[wptr_reg] <= in_item.raw_sample;
                wptr_reg          <= (wptr_reg == SP_W'(SMOOTH_TAPS - 1)) ? '0 : wptr_reg + 1'b1;
                scnt_reg          <= '0;
                ssum_reg          <= '0;
                needavg_reg       <= 1'b0;
                inst_reg          <= '0;
            end
            // One tap per cycle into the window sum.
            if (cmd.sum_step)
            begin
                ssum_reg <= ssum_reg + SSUM_W'(win_reg[scnt_reg[SP_W-1:0]]);
                scnt_reg <= scnt_reg + 1'b1;
            end
            // Register the smoothed value.
            if (cmd.thr_step)
            begin
                f_reg    <= avg_div;
                rmax_reg <= rmax_reg;
            end
            if (cmd.beat_step)
            begin
                // The threshold stage is folded here on the registered smoothed value.
                rmax_reg <= mx;
                rmin_reg <= mn;
                if (refresh)
                begin
                    thr_reg  <= (tadd > 11'(ebrd_pkg::LEVEL_MAX)) ? ebrd_pkg::LEVEL_MAX
                                                                 : tadd[9:0];
                    rmax_reg <= mx9[9:0];
                    rmin_reg <= mn9[9:0];
                    lthr_reg <= now_reg;
                end
            end
            // Beat decision uses the threshold written by the previous command.
            if (cmd.div_start)
            begin
                prev_reg    <= f_reg;
                conf_reg    <= conf;
                needdiv_reg <= ndiv;
                gap_reg     <= gap;
                track_reg   <= trk && !conf;
                peak_reg    <= (trk && f_reg > pk) ? f_reg : pk;
                if (conf)
                begin
                    lbeat_reg <= now_reg;
                    seen_reg  <= 1'b1;
                end
                dq_reg   <= ebrd_pkg::RATE_NUMER;
                drem_reg <= '0;
                dcnt_reg <= '0;
            end
            // Restoring division of 60000 by the beat gap, one bit a cycle.
            if (cmd.div_step)
            begin
                if (dsub[32])
                begin
                    drem_reg <= dtrial[QD_W-1:0];
                    dq_reg   <= {dq_reg[QD_W-2:0], 1'b0};
                end
                else
                begin
                    drem_reg <= dsub[QD_W-1:0];
                    dq_reg   <= {dq_reg[QD_W-2:0], 1'b1};
                end
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            // Rate into the average window; start the average division.
            if (cmd.avg_start)
            begin
                if (gap_reg == 32'd0)
                    inst_reg <= 8'd255;
                else
                    inst_reg <= (dq_reg > QD_W'(255)) ? 8'd255 : dq_reg[7:0];
                needavg_reg <= (gap_reg != 32'd0) && rate_ok;
                if (gap_reg != 32'd0 && rate_ok)
                begin
                    rsum_reg           <= rsum_new;
                    aq_reg             <= rsum_new;
                    rwin_reg[rptr_reg] <= dq_reg[7:0];
                    rptr_reg <= (rptr_reg == RP_W'(RATE_TAPS - 1)) ? '0 : rptr_reg + 1'b1;
                    if (rcnt_reg < RC_W'(RATE_TAPS))
                        rcnt_reg <= rcnt_reg + 1'b1;
                end
                arem_reg <= '0;
                acnt_reg <= '0;
            end
            // Restoring division of the rate sum by the count.
            if (cmd.avg_step)
            begin
                if (atrial >= {1'b0, rcnt_reg})
                begin
                    arem_reg <= atrial - {1'b0, rcnt_reg};
                    aq_reg   <= {aq_reg[AQ_W-2:0], 1'b1};
                end
                else
                begin
                    arem_reg <= atrial;
                    aq_reg   <= {aq_reg[AQ_W-2:0], 1'b0};
                end
                acnt_reg <= acnt_reg + 1'b1;
                if (acnt_reg == 5'(AQ_W - 1))
                    cur_reg <= 8'({aq_reg[AQ_W-2:0], (atrial >= {1'b0, rcnt_reg})});
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_reg.smoothed_sample <= f_reg;
            res_reg.level_threshold <= thr_reg;
            res_reg.beat_confirmed  <= conf_reg;
            res_reg.instant_rate    <= inst_reg;
            res_reg.average_rate    <= cur_reg;
        end
    end

    assign result       = res_reg;
    assign sts.sum_done = (scnt_reg == SC_W'(SMOOTH_TAPS));
    assign sts.need_div = needdiv_reg;
    assign sts.div_done = (dcnt_reg == 5'(QD_W));
    assign sts.need_avg = needavg_reg;
    assign sts.avg_done = (acnt_reg == 5'(AQ_W));

endmodule

[rtl/core/ebrd_ctrl.sv]
// Sequencing controller of the ECG beat rate detector.
module ebrd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  ebrd_pkg::dp_sts_t sts,
    output ebrd_pkg::dp_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_SUM, S_AVG, S_THR, S_BEAT, S_DIV, S_RATE, S_ADIV, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;
    logic   accept;

    // Accept only while the sequencer is idle; a waiting result does not block it.
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg;
        cmd         = '0;
        if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (sts.sum_done)
                    state_next = S_AVG;
                else
                    cmd.sum_step = 1'b1;
            end
            S_AVG:
            begin
                cmd.thr_step = 1'b1;
                state_next   = S_THR;
            end
            S_THR:
            begin
                cmd.beat_step = 1'b1;
                state_next    = S_BEAT;
            end
            S_BEAT:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (!sts.need_div)
                    state_next = S_DONE;
                else if (sts.div_done)
                begin
                    cmd.avg_start = 1'b1;
                    state_next    = S_RATE;
                end
                else
                    cmd.div_step = 1'b1;
            end
            S_RATE:
            begin
                state_next = sts.need_avg ? S_ADIV : S_DONE;
            end
            S_ADIV:
            begin
                if (sts.avg_done)
                    state_next = S_DONE;
                else
                    cmd.avg_step = 1'b1;
            end
            S_DONE:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    cmd.finish  = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;

endmodule

[rtl/core/ecg_beat_rate_detector.sv]
// Top level of the ECG beat rate detector: registers, controller and datapath.
// With no rate the result follows the window sum, threshold and beat steps; a
// rejected or zero-gap rate adds the 60000/interval divider, an accepted one
// also the average divider.
// One transaction at a time: the next is accepted in the cycle after the
// result is written. The result register frees the input while it waits.
// Reset (rst_n, asynchronous): registers to defaults, window to 512, rates to 0.
module ecg_beat_rate_detector #(
    parameter int SMOOTH_TAPS = ebrd_pkg::SMOOTH_TAPS_DEF,
    parameter int RATE_TAPS   = ebrd_pkg::RATE_TAPS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  ebrd_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output ebrd_pkg::out_item_t                 out_data,
    input  logic                                cfg_we,
    input  logic [ebrd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ebrd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    ebrd_pkg::cfg_t    cfg_reg;
    ebrd_pkg::dp_cmd_t cmd;
    ebrd_pkg::dp_sts_t sts;

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_gap   <= 16'd300;
            cfg_reg.max_gap   <= 16'd2000;
            cfg_reg.period    <= 16'd2000;
            cfg_reg.tenths    <= 4'd6;
            cfg_reg.rate_low  <= 8'd30;
            cfg_reg.rate_high <= 8'd200;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ebrd_pkg::REG_MIN_GAP:   cfg_reg.min_gap   <= cfg_data;
                ebrd_pkg::REG_MAX_GAP:   cfg_reg.max_gap   <= cfg_data;
                ebrd_pkg::REG_PERIOD:    cfg_reg.period    <= cfg_data;
                ebrd_pkg::REG_TENTHS:    cfg_reg.tenths    <= cfg_data[3:0];
                ebrd_pkg::REG_RATE_LOW:  cfg_reg.rate_low  <= cfg_data[7:0];
                ebrd_pkg::REG_RATE_HIGH: cfg_reg.rate_high <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    ebrd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ebrd_datapath #(
        .SMOOTH_TAPS (SMOOTH_TAPS),
        .RATE_TAPS   (RATE_TAPS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .in_item (in_data),
        .cmd     (cmd),
        .sts     (sts),
        .result  (out_data)
    );

    // A confirmed-beat result never carries a rate without the flag.
    a_rate_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.beat_confirmed |-> out_data.instant_rate == 8'd0)
        else $error("instant rate without a confirmed beat");

    // Only one datapath step is commanded in any cycle.
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.sum_step, cmd.thr_step, cmd.beat_step, cmd.div_start,
                  cmd.div_step, cmd.avg_start, cmd.avg_step, cmd.finish}))
        else $error("overlapping datapath commands");

    // A new transaction is never loaded while one is in flight.
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> in_stall)
        else $error("input taken while busy");

endmodule
